/* rtl/core/sbsh_pkg.sv */
// sha-1 byte stream hasher: shared constants and round helper functions
// no dependencies; imported by sha1_byte_stream_hasher
`timescale 1ns / 1ps
`default_nettype none

package sbsh_pkg;

  typedef logic [31:0] word_t;

  // chaining state after reset, h0 first
  localparam word_t H_INIT [5] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  // round constants, one per group of twenty rounds
  localparam word_t K_ROUND [4] = '{
    32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC, 32'hCA62C1D6
  };

  localparam logic [7:0] PAD_MARK = 8'h80;

  localparam logic [1:0] GRP_CH  = 2'd0;
  localparam logic [1:0] GRP_P1  = 2'd1;
  localparam logic [1:0] GRP_MAJ = 2'd2;
  localparam logic [1:0] GRP_P2  = 2'd3;

  // group of a round index 0..79
  function automatic logic [1:0] round_group(input logic [6:0] rnd);
    logic [1:0] g;
    if (rnd < 7'd20) begin
      g = GRP_CH;
    end else if (rnd < 7'd40) begin
      g = GRP_P1;
    end else if (rnd < 7'd60) begin
      g = GRP_MAJ;
    end else begin
      g = GRP_P2;
    end
    return g;
  endfunction

  // boolean function of the round group
  function automatic word_t round_f(input logic [1:0] grp, input word_t b,
                                    input word_t c, input word_t d);
    word_t f;
    case (grp)
      GRP_CH:  f = (b & c) | (~b & d);
      GRP_MAJ: f = (b & c) | (b & d) | (c & d);
      default: f = b ^ c ^ d;
    endcase
    return f;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/sha1_byte_stream_hasher.sv */
// sha-1 hasher taking at most one message byte per transaction, emitting a 160-bit digest
// depends on sbsh_pkg (constants, round function)
// the byte that fills a 64-byte block starts a compression: 80 rounds through the
// single round unit, then an add step; in_tready stays low meanwhile
// a last transaction appends the 0x80 byte, zero bytes and the length (up to 64 pad
// bytes), one or two compressions (none if too long), then loads the digest register
// rst_n is synchronous active low: chaining state back to the initial values, counts cleared
`timescale 1ns / 1ps
`default_nettype none

module sha1_byte_stream_hasher
  import sbsh_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  // input channel
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [7:0]   in_tdata,   // [7:0] msg_byte
  input  wire logic [0:0]   in_tuser,   // [0] byte_valid
  input  wire logic         in_tlast,   // last_byte
  // result channel
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [159:0]      out_tdata,  // [31:0] digest_word0 .. [159:128] digest_word4
  output logic [0:0]        out_tuser   // [0] hash_status
);

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;  // taking message bytes
  localparam logic [2:0] S_ROUND = 3'd1;  // 80 rounds, one per cycle
  localparam logic [2:0] S_ADD   = 3'd2;  // fold working vars into chaining state
  localparam logic [2:0] S_MARK  = 3'd3;  // append the 0x80 byte
  localparam logic [2:0] S_ZERO  = 3'd4;  // zero fill, then the bit length
  localparam logic [2:0] S_OUT   = 3'd5;  // load the digest into the output register

  localparam logic [5:0] IDX_LAST = 6'd63;
  localparam logic [5:0] IDX_LEN  = 6'd56;
  localparam logic [6:0] RND_LAST = 7'd79;

  logic [2:0]   state_r, state_nxt;
  word_t        h_r [5];
  word_t        h_nxt [5];
  logic [5:0]   idx_r, idx_nxt;        // bytes held in the block
  logic [60:0]  cnt_r, cnt_nxt;        // message length in bytes
  logic         tl_r, tl_nxt;          // message too long
  logic         fin_r, fin_nxt;        // message ended, padding under way
  logic         mark_r, mark_nxt;      // 0x80 byte already appended
  logic         len_r, len_nxt;        // length appended, block in flight is the final one
  logic [6:0]   rnd_r, rnd_nxt;
  logic         ovld_r, ovld_nxt;

  // block buffer and message schedule share one 512-bit shift line:
  // bytes shift in at the low end, schedule words leave at the high end
  logic [511:0] blk_r, blk_nxt;
  word_t        a_r, b_r, c_r, d_r, e_r;
  word_t        a_nxt, b_nxt, c_nxt, d_nxt, e_nxt;
  logic [159:0] odata_r, odata_nxt;
  logic         ostat_r, ostat_nxt;

  logic         absorb;
  logic         out_free;
  word_t        w_cur, w_new, w_mix, t_sum;
  logic [1:0]   grp;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = ovld_r;
  assign out_tdata  = odata_r;
  assign out_tuser  = ostat_r;

  assign absorb   = in_tuser[0] && !tl_r;
  assign out_free = !ovld_r || out_tready;

  // round unit: schedule word and the five-operand sum
  assign w_cur = blk_r[511:480];
  assign w_mix = blk_r[95:64] ^ blk_r[255:224] ^ blk_r[447:416] ^ blk_r[511:480];
  assign w_new = {w_mix[30:0], w_mix[31]};
  assign grp   = round_group(rnd_r);
  assign t_sum = {a_r[26:0], a_r[31:27]} + round_f(grp, b_r, c_r, d_r) + e_r + w_cur
               + K_ROUND[grp];

  always_comb begin
    state_nxt = state_r;
    h_nxt     = h_r;
    idx_nxt   = idx_r;
    cnt_nxt   = cnt_r;
    tl_nxt    = tl_r;
    fin_nxt   = fin_r;
    mark_nxt  = mark_r;
    len_nxt   = len_r;
    rnd_nxt   = rnd_r;
    ovld_nxt  = ovld_r && !out_tready;
    blk_nxt   = blk_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    c_nxt     = c_r;
    d_nxt     = d_r;
    e_nxt     = e_r;
    odata_nxt = odata_r;
    ostat_nxt = ostat_r;

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          if (absorb) begin
            blk_nxt = {blk_r[503:0], in_tdata};
            idx_nxt = idx_r + 6'd1;
            cnt_nxt = cnt_r + 61'd1;
            if (&cnt_r) begin
              tl_nxt = 1'b1;  // bit count wraps past 2^64
            end
          end
          if (in_tlast && tl_nxt) begin
            state_nxt = S_OUT;
          end else if (absorb && idx_r == IDX_LAST) begin
            state_nxt = S_ROUND;
            fin_nxt   = in_tlast;
          end else if (in_tlast) begin
            state_nxt = S_MARK;
            fin_nxt   = 1'b1;
          end
        end
      end
      S_ROUND: begin
        blk_nxt = {blk_r[479:0], w_new};
        a_nxt   = t_sum;
        b_nxt   = a_r;
        c_nxt   = {b_r[1:0], b_r[31:2]};
        d_nxt   = c_r;
        e_nxt   = d_r;
        rnd_nxt = rnd_r + 7'd1;
        if (rnd_r == RND_LAST) begin
          state_nxt = S_ADD;
        end
      end
      S_ADD: begin
        h_nxt[0] = h_r[0] + a_r;
        h_nxt[1] = h_r[1] + b_r;
        h_nxt[2] = h_r[2] + c_r;
        h_nxt[3] = h_r[3] + d_r;
        h_nxt[4] = h_r[4] + e_r;
        if (len_r) begin
          state_nxt = S_OUT;
        end else if (fin_r && !mark_r) begin
          state_nxt = S_MARK;
        end else if (fin_r) begin
          state_nxt = S_ZERO;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_MARK: begin
        blk_nxt  = {blk_r[503:0], PAD_MARK};
        idx_nxt  = idx_r + 6'd1;
        mark_nxt = 1'b1;
        state_nxt = (idx_r == IDX_LAST) ? S_ROUND : S_ZERO;
      end
      S_ZERO: begin
        if (idx_r == IDX_LEN) begin
          // big-endian bit length fills the last eight bytes
          blk_nxt   = {blk_r[447:0], cnt_r, 3'b000};
          idx_nxt   = '0;
          len_nxt   = 1'b1;
          state_nxt = S_ROUND;
        end else begin
          blk_nxt = {blk_r[503:0], 8'h00};
          idx_nxt = idx_r + 6'd1;
          if (idx_r == IDX_LAST) begin
            state_nxt = S_ROUND;
          end
        end
      end
      S_OUT: begin
        if (out_free) begin
          ovld_nxt  = 1'b1;
          ostat_nxt = tl_r;
          odata_nxt = tl_r ? '0 : {h_r[4], h_r[3], h_r[2], h_r[1], h_r[0]};
          h_nxt     = H_INIT;
          idx_nxt   = '0;
          cnt_nxt   = '0;
          tl_nxt    = 1'b0;
          fin_nxt   = 1'b0;
          mark_nxt  = 1'b0;
          len_nxt   = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // entering a compression: working vars from the chaining state
    if (state_nxt == S_ROUND && state_r != S_ROUND) begin
      a_nxt   = h_r[0];
      b_nxt   = h_r[1];
      c_nxt   = h_r[2];
      d_nxt   = h_r[3];
      e_nxt   = h_r[4];
      rnd_nxt = '0;
    end
  end

  // control and chaining state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      h_r     <= H_INIT;
      idx_r   <= '0;
      cnt_r   <= '0;
      tl_r    <= 1'b0;
      fin_r   <= 1'b0;
      mark_r  <= 1'b0;
      len_r   <= 1'b0;
      rnd_r   <= '0;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      h_r     <= h_nxt;
      idx_r   <= idx_nxt;
      cnt_r   <= cnt_nxt;
      tl_r    <= tl_nxt;
      fin_r   <= fin_nxt;
      mark_r  <= mark_nxt;
      len_r   <= len_nxt;
      rnd_r   <= rnd_nxt;
      ovld_r  <= ovld_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    blk_r   <= blk_nxt;
    a_r     <= a_nxt;
    b_r     <= b_nxt;
    c_r     <= c_nxt;
    d_r     <= d_nxt;
    e_r     <= e_nxt;
    odata_r <= odata_nxt;
    ostat_r <= ostat_nxt;
  end

  // a compression always starts on an empty block position
  a_round_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ROUND) |-> (idx_r == 6'd0 && rnd_r <= RND_LAST))
    else $error("round running with bytes pending or round count out of range");

  // the add step follows the final round
  a_add_after_round: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ADD) |-> ($past(state_r) == S_ROUND && $past(rnd_r) == RND_LAST))
    else $error("add step without a completed round sequence");

  // length only goes in after the marker of an ended message
  a_pad_order: assert property (@(posedge clk) disable iff (!rst_n)
    len_r |-> (fin_r && mark_r))
    else $error("length appended out of order");

  // an error result carries an all-zero digest
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |-> (out_tdata == 160'd0))
    else $error("too-long result with nonzero digest");

endmodule

`default_nettype wire
